// ===== rtl/gdm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gdm_pkg
// Shared widths, codes, reset values and types for the descent phase glide
// monitor.
// ============================================================================
package gdm_pkg;

    // Field widths
    localparam int HEIGHT_W   = 26;
    localparam int VDOWN_W    = 19;
    localparam int GSPEED_W   = 18;
    localparam int ELEV_W     = 25;
    localparam int ALT_M_W    = 14;
    localparam int SPEED_W    = 8;
    localparam int PHASE_W    = 3;
    localparam int CUE_W      = 3;
    localparam int ERR_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Internal widths
    localparam int DIFF_W  = HEIGHT_W + 1;   // height minus elevation
    localparam int ALT_Q_W = 17;             // |altitude| in metres
    localparam int ALT_W   = ALT_Q_W + 1;    // signed altitude in metres
    localparam int NOM_W   = 8;              // nominal ratio, at most 180

    // Serial divider geometry
    localparam int DIV_W     = DIFF_W;                  // dividend register
    localparam int DVSR_W    = 15;                      // largest divisor
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int ALT_BITS  = DIFF_W;                  // |height - elevation|
    localparam int VMAG_BITS = VDOWN_W;                 // |down velocity|
    localparam int PROD_BITS = 25;                      // ground speed * 100
    localparam int NOM_BITS  = 11;                      // nominal slope term

    // Scale constants
    localparam int ALT_SCALE        = 1000;  // mm to m
    localparam int VEL_SCALE        = 10;    // mm/s to cm/s
    localparam int GLIDE_SCALE      = 100;   // ratio in hundredths
    localparam int EXIT_SPEED_SCALE = 1000;  // m/s to mm/s

    // Nominal glide ratio curve
    localparam int NOM_HIGH_ALT  = 2800;
    localparam int NOM_MID_ALT   = 2500;
    localparam int NOM_LOW_ALT   = 1500;
    localparam int NOM_FLAT_HIGH = 80;
    localparam int NOM_MID_BASE  = 100;
    localparam int NOM_LOW_BASE  = 180;
    // x*20/300 == x/15 ; x*80/1000 == 2x/25
    localparam int NOM_MID_DIV   = 300 / 20;
    localparam int NOM_LOW_MUL   = 80 / 40;
    localparam int NOM_LOW_DIV   = 1000 / 40;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_CLIMB = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AWAIT = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ABOVE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_IN    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

    // Cue codes
    localparam logic [CUE_W-1:0] CUE_NONE     = 3'd0;
    localparam logic [CUE_W-1:0] CUE_EXIT_ALT = 3'd1;
    localparam logic [CUE_W-1:0] CUE_EXIT     = 3'd2;
    localparam logic [CUE_W-1:0] CUE_TOO_HIGH = 3'd3;
    localparam logic [CUE_W-1:0] CUE_TOO_LOW  = 3'd4;
    localparam logic [CUE_W-1:0] CUE_WIN_IN   = 3'd5;
    localparam logic [CUE_W-1:0] CUE_WIN_OUT  = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOT  = 3'd5;

    // Register reset values
    localparam logic [ELEV_W-1:0]  RST_ELEV    = 25'd0;
    localparam logic [ALT_M_W-1:0] RST_FLOOR   = 14'd3000;
    localparam logic [ALT_M_W-1:0] RST_CEILING = 14'd4500;
    localparam logic [SPEED_W-1:0] RST_SPEED   = 8'd10;
    localparam logic [ALT_M_W-1:0] RST_WIN_TOP = 14'd2500;
    localparam logic [ALT_M_W-1:0] RST_WIN_BOT = 14'd1500;

    // Configuration register file
    typedef struct packed {
        logic signed [ELEV_W-1:0] ground_elevation_mm;
        logic [ALT_M_W-1:0]       exit_floor_m;
        logic [ALT_M_W-1:0]       exit_ceiling_m;
        logic [SPEED_W-1:0]       exit_speed_mps;
        logic [ALT_M_W-1:0]       window_top_m;
        logic [ALT_M_W-1:0]       window_bottom_m;
    } t_cfg;

    // Sequencer control
    typedef struct packed {
        logic clear;
        logic update;
    } t_phase_ctl;

endpackage

// ===== rtl/gdm_sdiv.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gdm_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out MSB first while the quotient shifts in at the bottom.
// ============================================================================
module gdm_sdiv
    import gdm_pkg::*;
#(
    parameter int DIVIDEND_W = DIV_W,
    parameter int DIVISOR_W  = DVSR_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVIDEND_W-1:0]         i_dividend,  // MSB-aligned
    input  logic [DIVISOR_W-1:0]          i_divisor,
    input  logic [$clog2(DIVIDEND_W+1)-1:0] i_count,   // quotient bits
    output logic                          o_done,
    output logic [DIVIDEND_W-1:0]         o_quot
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_d;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_sub;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // One restoring step
    always_comb begin
        w_trial = {r_rem, r_q[DIVIDEND_W-1]};
        w_sub   = w_trial - {1'b0, r_d};
        w_ge    = (w_trial >= {1'b0, r_d});
        n_rem   = w_ge ? w_sub[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
    end

    // Step counter and shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
                r_cnt  <= i_count;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DIVIDEND_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/gdm_phase.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gdm_phase
// Five-phase jump sequencer: holds the phase and produces the cue for each
// navigation sample once its altitude is known.
// ============================================================================
module gdm_phase
    import gdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_phase_ctl               i_ctl,
    input  t_cfg                     i_cfg,
    input  logic signed [ALT_W-1:0]  i_alt,
    input  logic signed [VDOWN_W-1:0] i_vdown,
    input  logic                     i_idle,
    output logic [PHASE_W-1:0]       o_phase,
    output logic [CUE_W-1:0]         o_cue
);

    logic [PHASE_W-1:0] r_phase;
    logic [CUE_W-1:0]   r_cue;
    logic [PHASE_W-1:0] n_phase;
    logic [CUE_W-1:0]   n_cue;

    logic signed [ALT_W-1:0]  w_floor;
    logic signed [ALT_W-1:0]  w_ceil;
    logic signed [ALT_W-1:0]  w_top;
    logic signed [ALT_W-1:0]  w_bot;
    logic [VDOWN_W-2:0]       w_exit_v;

    // Thresholds widened to signed altitude / velocity
    always_comb begin
        w_floor  = $signed({{(ALT_W-ALT_M_W){1'b0}}, i_cfg.exit_floor_m});
        w_ceil   = $signed({{(ALT_W-ALT_M_W){1'b0}}, i_cfg.exit_ceiling_m});
        w_top    = $signed({{(ALT_W-ALT_M_W){1'b0}}, i_cfg.window_top_m});
        w_bot    = $signed({{(ALT_W-ALT_M_W){1'b0}}, i_cfg.window_bottom_m});
        w_exit_v = (VDOWN_W-1)'(i_cfg.exit_speed_mps) * (VDOWN_W-1)'(EXIT_SPEED_SCALE);
    end

    // Transition rules
    always_comb begin
        n_phase = r_phase;
        n_cue   = CUE_NONE;
        case (r_phase)
            PH_CLIMB: begin
                if (i_alt > w_floor) begin
                    n_phase = PH_AWAIT;
                    n_cue   = CUE_EXIT_ALT;
                end
            end
            PH_AWAIT: begin
                if (i_vdown > $signed({1'b0, w_exit_v})) begin
                    n_phase = PH_ABOVE;
                    n_cue   = CUE_EXIT;
                end else if (i_idle) begin
                    if (i_alt > w_ceil) begin
                        n_cue = CUE_TOO_HIGH;
                    end else if (i_alt < w_floor) begin
                        n_cue = CUE_TOO_LOW;
                    end
                end
            end
            PH_ABOVE: begin
                if (i_alt < w_top) begin
                    n_phase = PH_IN;
                    n_cue   = CUE_WIN_IN;
                end
            end
            PH_IN: begin
                if (i_alt < w_bot) begin
                    n_phase = PH_DONE;
                    n_cue   = CUE_WIN_OUT;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Phase and cue registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CLIMB;
            r_cue   <= CUE_NONE;
        end else if (i_ctl.clear) begin
            r_phase <= PH_CLIMB;
            r_cue   <= CUE_NONE;
        end else if (i_ctl.update) begin
            r_phase <= n_phase;
            r_cue   <= n_cue;
        end
    end

    assign o_phase = r_phase;
    assign o_cue   = r_cue;

    // Restart returns to climb with no cue
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_phase == PH_CLIMB) && (r_cue == CUE_NONE))
        else $error("phase not cleared by restart");

    // A sample moves the phase forward by at most one
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.update |=> (r_phase == $past(r_phase)) ||
                         (r_phase == PHASE_W'($past(r_phase) + 3'd1)))
        else $error("phase skipped");

    // A phase change always carries a transition cue, and only then
    a_cue_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.update |=> ((r_phase != $past(r_phase)) ==
                          ((r_cue == CUE_EXIT_ALT) || (r_cue == CUE_EXIT) ||
                           (r_cue == CUE_WIN_IN) || (r_cue == CUE_WIN_OUT))))
        else $error("cue disagrees with phase change");

    // Without a request the sequencer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.clear && !i_ctl.update) |=> $stable(r_phase) && $stable(r_cue))
        else $error("sequencer moved without a request");

endmodule

// ===== rtl/descent_phase_glide_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// descent_phase_glide_monitor
// Jump phase sequencer with cue codes and glide-ratio error per navigation
// sample.
// ============================================================================
// One request is in flight at a time. Two bit-serial dividers work side by
// side. The first produces altitude (27 bits) and then, on the sloped parts
// of the nominal curve, the slope term (11 bits). The second produces down
// velocity / 10 (19 bits) and then, when a glide figure is due, the ground
// speed * 100 quotient (25 bits). A restart request uses no divider and
// moves to the output register as soon as that register is free. A stalled
// output holds back the hand-over of a finished sample. A new request is
// taken as soon as the previous one has moved into the output register,
// even while that result is still stalled. Configuration writes are taken
// at any cycle and must only be issued while no request is in flight.
// ============================================================================
module descent_phase_glide_monitor
    import gdm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic signed [HEIGHT_W-1:0] i_height_mm,
    input  logic signed [VDOWN_W-1:0]  i_down_velocity,
    input  logic [GSPEED_W-1:0]        i_ground_speed,
    input  logic                       i_audio_idle,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [PHASE_W-1:0]         o_phase_now,
    output logic [CUE_W-1:0]           o_cue,
    output logic signed [ERR_W-1:0]    o_glide_error,
    output logic                       o_glide_valid,
    // Configuration write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic {S_IDLE, S_RUN} t_state;
    typedef enum logic [1:0] {A_ALT, A_NOMSET, A_NOM, A_FIN} t_a_step;
    typedef enum logic [1:0] {B_VDIV, B_QUO, B_FIN} t_b_step;

    localparam logic signed [ALT_W-1:0] ALT_HIGH = ALT_W'(NOM_HIGH_ALT);
    localparam logic signed [ALT_W-1:0] ALT_MID  = ALT_W'(NOM_MID_ALT);
    localparam logic signed [ALT_W-1:0] ALT_LOW  = ALT_W'(NOM_LOW_ALT);

    t_state                   r_state;
    t_a_step                  r_a_step;
    t_b_step                  r_b_step;
    t_cfg                     r_cfg;

    logic                     r_alt_neg;
    logic                     r_v_neg;
    logic signed [VDOWN_W-1:0] r_vdown;
    logic [GSPEED_W-1:0]      r_gs;
    logic                     r_idle;
    logic                     r_glide_en;
    logic signed [ALT_W-1:0]  r_alt;
    logic [NOM_W-1:0]         r_nom;
    logic [NOM_W-1:0]         r_nom_base;
    logic signed [ERR_W-1:0]  r_qs;
    logic                     r_gvalid;

    logic                     r_out_valid;
    logic [PHASE_W-1:0]       r_phase_now;
    logic [CUE_W-1:0]         r_cue;
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_err_valid;

    logic                     w_accept;
    logic signed [DIFF_W-1:0] w_diff_ab;
    logic signed [DIFF_W-1:0] w_diff_ba;
    logic [DIFF_W-1:0]        w_alt_mag;
    logic [VMAG_BITS-1:0]     w_v_mag;
    logic [PROD_BITS-1:0]     w_prod;

    logic signed [ALT_W-1:0]  w_alt_mid;
    logic signed [ALT_W-1:0]  w_alt_low;
    logic                     w_nom_need;
    logic [NOM_W-1:0]         w_nom_base;
    logic [NOM_BITS-1:0]      w_nom_x;
    logic [DVSR_W-1:0]        w_nom_dvsr;

    logic                     w_a_start;
    logic [DIV_W-1:0]         w_a_dividend;
    logic [DVSR_W-1:0]        w_a_divisor;
    logic [CNT_W-1:0]         w_a_count;
    logic                     w_a_done;
    logic [DIV_W-1:0]         w_a_quot;

    logic                     w_b_start;
    logic [DIV_W-1:0]         w_b_dividend;
    logic [DVSR_W-1:0]        w_b_divisor;
    logic [CNT_W-1:0]         w_b_count;
    logic                     w_b_done;
    logic [DIV_W-1:0]         w_b_quot;

    logic [DVSR_W-1:0]        w_div_mag;
    logic                     w_quo_go;
    logic signed [ALT_W-1:0]  w_alt_val;
    logic signed [ERR_W-1:0]  w_q_val;
    logic signed [ERR_W-1:0]  w_err;
    logic                     w_finish;

    t_phase_ctl               w_ctl;
    logic [PHASE_W-1:0]       w_phase;
    logic [CUE_W-1:0]         w_cue;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Magnitudes for the first divisions
    always_comb begin
        w_diff_ab = $signed({i_height_mm[HEIGHT_W-1], i_height_mm}) -
                    $signed({{(DIFF_W-ELEV_W){r_cfg.ground_elevation_mm[ELEV_W-1]}},
                             r_cfg.ground_elevation_mm});
        w_diff_ba = $signed({{(DIFF_W-ELEV_W){r_cfg.ground_elevation_mm[ELEV_W-1]}},
                             r_cfg.ground_elevation_mm}) -
                    $signed({i_height_mm[HEIGHT_W-1], i_height_mm});
        w_alt_mag = w_diff_ab[DIFF_W-1] ? w_diff_ba : w_diff_ab;
        w_v_mag   = i_down_velocity[VDOWN_W-1] ? VMAG_BITS'(-i_down_velocity)
                                               : VMAG_BITS'(i_down_velocity);
        w_prod    = PROD_BITS'(r_gs) * PROD_BITS'(GLIDE_SCALE);
    end

    // Nominal curve segment select
    always_comb begin
        w_alt_mid  = r_alt - ALT_MID;
        w_alt_low  = r_alt - ALT_LOW;
        w_nom_need = 1'b0;
        w_nom_base = NOM_W'(NOM_LOW_BASE);
        w_nom_x    = w_alt_mid[NOM_BITS-1:0];
        w_nom_dvsr = DVSR_W'(NOM_MID_DIV);
        if (r_alt > ALT_HIGH) begin
            w_nom_base = NOM_W'(NOM_FLAT_HIGH);
        end else if (r_alt > ALT_MID) begin
            w_nom_need = 1'b1;
            w_nom_base = NOM_W'(NOM_MID_BASE);
        end else if (r_alt > ALT_LOW) begin
            w_nom_need = 1'b1;
            w_nom_x    = NOM_BITS'(w_alt_low[NOM_BITS-1:0] * NOM_BITS'(NOM_LOW_MUL));
            w_nom_dvsr = DVSR_W'(NOM_LOW_DIV);
        end
    end

    // Lane results
    always_comb begin
        w_div_mag = w_b_quot[DVSR_W-1:0];
        w_quo_go  = r_glide_en && (w_div_mag != '0);
        w_alt_val = r_alt_neg ? -$signed({1'b0, w_a_quot[ALT_Q_W-1:0]})
                              :  $signed({1'b0, w_a_quot[ALT_Q_W-1:0]});
        w_q_val   = r_v_neg ? -$signed({1'b0, w_b_quot[PROD_BITS-1:0]})
                            :  $signed({1'b0, w_b_quot[PROD_BITS-1:0]});
        w_err     = r_qs - $signed({{(ERR_W-NOM_W){1'b0}}, r_nom});
        w_finish  = (r_state == S_RUN) && (r_a_step == A_FIN) &&
                    (r_b_step == B_FIN) && (!r_out_valid || !i_out_stall);
    end

    // Divider lane A: altitude, then nominal slope term
    always_comb begin
        w_a_start    = 1'b0;
        w_a_dividend = w_alt_mag;
        w_a_divisor  = DVSR_W'(ALT_SCALE);
        w_a_count    = CNT_W'(ALT_BITS);
        if (w_accept && !i_op) begin
            w_a_start = 1'b1;
        end else if ((r_state == S_RUN) && (r_a_step == A_NOMSET) && w_nom_need) begin
            w_a_start    = 1'b1;
            w_a_dividend = {w_nom_x, {(DIV_W-NOM_BITS){1'b0}}};
            w_a_divisor  = w_nom_dvsr;
            w_a_count    = CNT_W'(NOM_BITS);
        end
    end

    // Divider lane B: velocity / 10, then ratio quotient
    always_comb begin
        w_b_start    = 1'b0;
        w_b_dividend = {w_v_mag, {(DIV_W-VMAG_BITS){1'b0}}};
        w_b_divisor  = DVSR_W'(VEL_SCALE);
        w_b_count    = CNT_W'(VMAG_BITS);
        if (w_accept && !i_op) begin
            w_b_start = 1'b1;
        end else if ((r_state == S_RUN) && (r_b_step == B_VDIV) && w_b_done && w_quo_go) begin
            w_b_start    = 1'b1;
            w_b_dividend = {w_prod, {(DIV_W-PROD_BITS){1'b0}}};
            w_b_divisor  = w_div_mag;
            w_b_count    = CNT_W'(PROD_BITS);
        end
    end

    // Sequencer control
    always_comb begin
        w_ctl.clear  = w_accept && i_op;
        w_ctl.update = (r_state == S_RUN) && (r_a_step == A_NOMSET);
    end

    gdm_sdiv #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVSR_W)
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_a_start),
        .i_dividend (w_a_dividend),
        .i_divisor  (w_a_divisor),
        .i_count    (w_a_count),
        .o_done     (w_a_done),
        .o_quot     (w_a_quot)
    );

    gdm_sdiv #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVSR_W)
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_b_start),
        .i_dividend (w_b_dividend),
        .i_divisor  (w_b_divisor),
        .i_count    (w_b_count),
        .o_done     (w_b_done),
        .o_quot     (w_b_quot)
    );

    gdm_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_alt   (r_alt),
        .i_vdown (r_vdown),
        .i_idle  (r_idle),
        .o_phase (w_phase),
        .o_cue   (w_cue)
    );

    // Control, lanes, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                   <= S_IDLE;
            r_a_step                  <= A_FIN;
            r_b_step                  <= B_FIN;
            r_out_valid               <= 1'b0;
            r_cfg.ground_elevation_mm <= RST_ELEV;
            r_cfg.exit_floor_m        <= RST_FLOOR;
            r_cfg.exit_ceiling_m      <= RST_CEILING;
            r_cfg.exit_speed_mps      <= RST_SPEED;
            r_cfg.window_top_m        <= RST_WIN_TOP;
            r_cfg.window_bottom_m     <= RST_WIN_BOT;
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ELEV:    r_cfg.ground_elevation_mm <= i_cfg_data[ELEV_W-1:0];
                    REG_FLOOR:   r_cfg.exit_floor_m        <= i_cfg_data[ALT_M_W-1:0];
                    REG_CEILING: r_cfg.exit_ceiling_m      <= i_cfg_data[ALT_M_W-1:0];
                    REG_SPEED:   r_cfg.exit_speed_mps      <= i_cfg_data[SPEED_W-1:0];
                    REG_WIN_TOP: r_cfg.window_top_m        <= i_cfg_data[ALT_M_W-1:0];
                    REG_WIN_BOT: r_cfg.window_bottom_m     <= i_cfg_data[ALT_M_W-1:0];
                    default: begin
                    end
                endcase
            end

            // result taken downstream, no new one behind it
            if (r_out_valid && !i_out_stall && !w_finish) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_RUN;
                        r_alt_neg  <= w_diff_ab[DIFF_W-1];
                        r_v_neg    <= i_down_velocity[VDOWN_W-1];
                        r_vdown    <= i_down_velocity;
                        r_gs       <= i_ground_speed;
                        r_idle     <= i_audio_idle;
                        r_gvalid   <= 1'b0;
                        r_glide_en <= !i_op && ((w_phase == PH_ABOVE) || (w_phase == PH_IN));
                        if (i_op) begin
                            r_a_step <= A_FIN;
                            r_b_step <= B_FIN;
                        end else begin
                            r_a_step <= A_ALT;
                            r_b_step <= B_VDIV;
                        end
                    end
                end
                S_RUN: begin
                    // lane A
                    case (r_a_step)
                        A_ALT: begin
                            if (w_a_done) begin
                                r_alt    <= w_alt_val;
                                r_a_step <= A_NOMSET;
                            end
                        end
                        A_NOMSET: begin
                            r_nom      <= w_nom_base;
                            r_nom_base <= w_nom_base;
                            r_a_step   <= w_nom_need ? A_NOM : A_FIN;
                        end
                        A_NOM: begin
                            if (w_a_done) begin
                                r_nom    <= r_nom_base - w_a_quot[NOM_W-1:0];
                                r_a_step <= A_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // lane B
                    case (r_b_step)
                        B_VDIV: begin
                            if (w_b_done) begin
                                r_b_step <= w_quo_go ? B_QUO : B_FIN;
                            end
                        end
                        B_QUO: begin
                            if (w_b_done) begin
                                r_qs     <= w_q_val;
                                r_gvalid <= 1'b1;
                                r_b_step <= B_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // hand the result to the output register
                    if (w_finish) begin
                        r_out_valid <= 1'b1;
                        r_phase_now <= w_phase;
                        r_cue       <= w_cue;
                        r_err       <= r_gvalid ? w_err : '0;
                        r_err_valid <= r_gvalid;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_phase_now   = r_phase_now;
    assign o_cue         = r_cue;
    assign o_glide_error = r_err;
    assign o_glide_valid = r_err_valid;

endmodule
